/* sv/assert_macros.svh */
// assertion macros used by the rtl files (timer_table_scheduler)
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define TTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/tts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants for the timer table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned ID_W      = 31;
  localparam int unsigned IVL_W     = 31;
  localparam int unsigned NOW_W     = 63;
  localparam int unsigned DL_W      = 64;

  // input operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [ID_W-1:0]  rm_id;
    logic [IVL_W-1:0] interval;
    logic             repeat_req;
    logic [NOW_W-1:0] now;
  } tts_req_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] fired_id;
    logic [1:0]      status;
    logic            last;
  } tts_res_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [IVL_W-1:0] ivl;
    logic [DL_W-1:0]  deadline;
    logic             periodic;
  } tts_slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } tts_state_e;

endpackage
`default_nettype wire

/* sv/tts_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/timer_table_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer_table_scheduler
// Table of software timers: add, remove and tick items, each handled by one
// sequential scan over the slots.
//
//   channel   ports                      handshake
//   request   req_i                      start & !busy
//   result    res_o                      res_valid_o strobe, one cycle, no stall
//
// Add, remove and tick each walk the slot memory once, one slot per cycle,
// through a one-deep read pipeline; add and remove end the scan early when a
// slot is found, and tick ends with a pass through the finish state.
// Op code 3 is taken and dropped without going busy.
// The result register shows each result in the cycle after it is decided; the
// next item may be started while the last result is still on the port.
// Reset clears the valid bits, the id counter and the sequencer; the slot
// memory itself is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timer_table_scheduler import tts_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire tts_req_t req_i,
  output logic          res_valid_o,
  output tts_res_t      res_o
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_W = $bits(tts_slot_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  tts_state_e state_q, state_d;

  tts_req_t   req_q;
  logic       issue_q, issue_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic       ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [ID_W-1:0]  id_cnt_q, id_cnt_d;
  logic       res_vld_q, res_vld_d;
  tts_res_t   res_q, res_d;

  logic       accept;
  logic       ram_we;
  tts_slot_t  ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  tts_slot_t  slot_rd;

  // shared deadline adder and compare
  logic [IVL_W-1:0] add_ivl;
  logic [DL_W-1:0]  new_deadline;
  logic             expired;
  logic             cur_valid;
  logic             at_last;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign slot_rd = tts_slot_t'(ram_rdata);

  assign add_ivl      = (req_q.op == OP_ADD) ? req_q.interval : slot_rd.ivl;
  assign new_deadline = {1'b0, req_q.now} + {{(DL_W - IVL_W){1'b0}}, add_ivl};
  assign expired      = ({1'b0, req_q.now} >= slot_rd.deadline);
  assign cur_valid    = valid_q[ev_idx_q];
  assign at_last      = (ev_idx_q == LAST_IDX);

  tts_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ev_idx_q),
    .wdata_i (SLOT_W'(ram_wdata)),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= 1'b0;
      rd_idx_q  <= '0;
      ev_vld_q  <= 1'b0;
      ev_idx_q  <= '0;
      valid_q   <= '0;
      id_cnt_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      rd_idx_q  <= rd_idx_d;
      ev_vld_q  <= ev_vld_d;
      ev_idx_q  <= ev_idx_d;
      valid_q   <= valid_d;
      id_cnt_q  <= id_cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    issue_d   = issue_q;
    rd_idx_d  = rd_idx_q;
    ev_vld_d  = 1'b0;
    ev_idx_d  = ev_idx_q;
    valid_d   = valid_q;
    id_cnt_d  = id_cnt_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_wdata = slot_rd;

    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.op == OP_ADD || req_i.op == OP_REMOVE ||
                       req_i.op == OP_TICK)) begin
          state_d  = ST_SCAN;
          issue_d  = 1'b1;
          rd_idx_d = '0;
        end
      end

      ST_SCAN: begin
        // read issue stage
        if (issue_q) begin
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx_q;
          if (rd_idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
          end
        end

        // evaluate stage, memory data belongs to ev_idx_q
        if (ev_vld_q) begin
          case (req_q.op)
            OP_ADD: begin
              if (!cur_valid) begin
                ram_we             = 1'b1;
                ram_wdata.id       = id_cnt_q;
                ram_wdata.ivl      = req_q.interval;
                ram_wdata.deadline = new_deadline;
                ram_wdata.periodic = req_q.repeat_req;
                valid_d[ev_idx_q]  = 1'b1;
                id_cnt_d           = id_cnt_q + ID_W'(1);
                res_vld_d          = 1'b1;
                res_d              = '{kind: KIND_ADD, fired_id: id_cnt_q,
                                       status: ST_OK, last: 1'b1};
                state_d            = ST_IDLE;
                issue_d            = 1'b0;
              end else if (at_last) begin
                res_vld_d = 1'b1;
                res_d     = '{kind: KIND_ADD, fired_id: '0,
                              status: ST_FULL, last: 1'b1};
                state_d   = ST_IDLE;
              end
            end

            OP_REMOVE: begin
              if (cur_valid && slot_rd.id == req_q.rm_id) begin
                valid_d[ev_idx_q] = 1'b0;
                res_vld_d         = 1'b1;
                res_d             = '{kind: KIND_REMOVE, fired_id: req_q.rm_id,
                                      status: ST_OK, last: 1'b1};
                state_d           = ST_IDLE;
                issue_d           = 1'b0;
              end else if (at_last) begin
                res_vld_d = 1'b1;
                res_d     = '{kind: KIND_REMOVE, fired_id: req_q.rm_id,
                              status: ST_NOT_FOUND, last: 1'b1};
                state_d   = ST_IDLE;
              end
            end

            default: begin
              if (cur_valid && expired) begin
                res_vld_d = 1'b1;
                res_d     = '{kind: KIND_FIRED, fired_id: slot_rd.id,
                              status: ST_OK, last: 1'b0};
                if (slot_rd.periodic) begin
                  ram_we             = 1'b1;
                  ram_wdata.deadline = new_deadline;
                end else begin
                  valid_d[ev_idx_q] = 1'b0;
                end
              end
              if (at_last) begin
                state_d = ST_FINISH;
              end
            end
          endcase
        end
      end

      ST_FINISH: begin
        res_vld_d = 1'b1;
        res_d     = '{kind: KIND_DONE, fired_id: '0, status: ST_OK, last: 1'b1};
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // every scan closes with a final result
  `TTS_ASSERT_IMP(a_busy_ends_last, $fell(busy), res_valid_o && res_o.last,
                  "scan ended without a final result")
  // results come only out of a scan
  `TTS_ASSERT_IMP(a_res_from_scan, res_valid_o, $past(busy),
                  "result transfer without a preceding scan")
  // a final result leaves the block free for the next item
  `TTS_ASSERT_IMP(a_last_not_busy, res_valid_o && res_o.last, !busy,
                  "still busy after final result")
  // fired results are not final and come while the block is still busy
  `TTS_ASSERT_IMP(a_fired_mid_tick, res_valid_o && res_o.kind == KIND_FIRED,
                  !res_o.last && busy, "fired result out of tick sequence")

endmodule
`default_nettype wire
